// File: sv/random_walk_maze_carver_unit_macros.svh
// Assertion macros for the maze carver.
// Both expect clk and rst_n in scope at the point of use.
`ifndef RANDOM_WALK_MAZE_CARVER_UNIT_MACROS_SVH
`define RANDOM_WALK_MAZE_CARVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Holds at every clock edge outside reset.
`define RWMC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rwmc check failed");

// Cause in one cycle, effect in the next.
`define RWMC_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("rwmc sequencing check failed");

`else

`define RWMC_ASSERT_ALWAYS(lbl, cond)
`define RWMC_ASSERT_NEXT(lbl, cause, effect)

`endif

`endif

// File: sv/rwmc_pkg.sv
package rwmc_pkg;

  localparam int MAX_DIM   = 64;
  localparam int HALF_DIM  = MAX_DIM / 2;
  localparam int MAP_DEPTH = HALF_DIM * HALF_DIM;
  localparam int IDX_W     = $clog2(MAP_DEPTH);
  localparam int HALF_W    = $clog2(HALF_DIM);
  localparam int CNT_W     = $clog2(MAP_DEPTH + 1);

  localparam int COORD_W = 6;
  localparam int DIM_W   = 7;
  localparam int RND_W   = 16;

  // request operation codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // register select (paddr bit 2)
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] wx;
    logic [COORD_W-1:0] wy;
    logic [IDX_W-1:0]   idx;
  } pick_t;

  typedef struct packed {
    logic             done;
    logic [RND_W-1:0] quot;
    logic [CNT_W-1:0] rem;
  } div_res_t;

endpackage

// File: sv/random_walk_maze_carver_unit.sv
// Step request: visited bit read on acceptance, reported once the slot is free.
// Begin request: sweep of all 1024 visited-map entries, then ST_START marks the
//   start cell once it is known and the slot is free; its division overlaps the
//   sweep. No request is taken until the previous one has reported.
// Pace set by the visited map: one read then one write-back per step.
// Reset (rst_n low, synchronous): the same sweep runs with in_ready low.
`include "random_walk_maze_carver_unit_macros.svh"

module random_walk_maze_carver_unit
  import rwmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [RND_W-1:0]   in_random_value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_wall_x,
  output logic [COORD_W-1:0] out_wall_y,
  output logic               out_carved,
  output logic [COORD_W-1:0] out_cell_x,
  output logic [COORD_W-1:0] out_cell_y,
  output logic               out_finished,
  // APB-style config port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;  // sweeping the visited map
  localparam logic [1:0] ST_IDLE  = 2'd1;  // waiting for a request
  localparam logic [1:0] ST_STEP  = 2'd2;  // visited bit back, write it and report
  localparam logic [1:0] ST_START = 2'd3;  // mark start cell after a begin

  // Saturate a dimension to 3..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_W'(3))            clamp_dim = DIM_W'(3);
    else if (v > DIM_W'(MAX_DIM)) clamp_dim = DIM_W'(MAX_DIM);
    else                          clamp_dim = v;
  endfunction

  // ---------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------
  logic [DIM_W-1:0] grid_w_r, grid_h_r;
  logic             cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= DIM_W'(21);
      grid_h_r <= DIM_W'(21);
    end else if (cfg_we) begin
      unique case (cfg_paddr[2])
        REG_GRID_WIDTH:  grid_w_r <= cfg_pwdata[DIM_W-1:0];
        default:         grid_h_r <= cfg_pwdata[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_GRID_WIDTH: cfg_prdata = {{(32-DIM_W){1'b0}}, grid_w_r};
      default:        cfg_prdata = {{(32-DIM_W){1'b0}}, grid_h_r};
    endcase
  end

  // Effective geometry; open cells live on odd rows and columns
  logic [DIM_W-1:0]   dim_w, dim_h;
  logic [COORD_W-1:0] cols, rows;
  logic [2*COORD_W-1:0] cells_full;
  logic [CNT_W-1:0]   cells;

  assign dim_w      = clamp_dim(grid_w_r);
  assign dim_h      = clamp_dim(grid_h_r);
  assign cols       = dim_w[DIM_W-1:1];
  assign rows       = dim_h[DIM_W-1:1];
  assign cells_full = cols * rows;
  assign cells      = cells_full[CNT_W-1:0];

  // ---------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------
  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic               begin_pend_r, begin_pend_nxt;
  logic [COORD_W-1:0] walk_x_r, walk_x_nxt;
  logic [COORD_W-1:0] walk_y_r, walk_y_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  pick_t              pick_r, pick_nxt;

  // start-cell division: rnd % cells, then that index / rows
  logic               div_phase_r, div_phase_nxt;
  logic               start_rdy_r, start_rdy_nxt;
  logic [HALF_W-1:0]  start_col_r, start_col_nxt;
  logic [HALF_W-1:0]  start_row_r, start_row_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_wall_x_r, out_wall_x_nxt;
  logic [COORD_W-1:0] out_wall_y_r, out_wall_y_nxt;
  logic               out_carved_r, out_carved_nxt;
  logic [COORD_W-1:0] out_cell_x_r, out_cell_x_nxt;
  logic [COORD_W-1:0] out_cell_y_r, out_cell_y_nxt;
  logic               out_fin_r, out_fin_nxt;

  // visited map: one write port, one registered read port
  logic               vmap_mem [MAP_DEPTH];
  logic               rd_data_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_data;

  // ---------------------------------------------------------------
  // Neighbour choice and divider
  // ---------------------------------------------------------------
  pick_t              pick;
  div_res_t           div_res;
  logic               div_start;
  logic [RND_W-1:0]   div_dividend;
  logic [CNT_W-1:0]   div_divisor;

  rwmc_pick u_pick (
    .walk_x (walk_x_r),
    .walk_y (walk_y_r),
    .dim_w  (dim_w),
    .dim_h  (dim_h),
    .rnd    (in_random_value),
    .pick   (pick)
  );

  rwmc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  logic in_acc, out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  // result slot free this cycle (empty, or being taken)
  assign out_free = !out_valid_r || out_ready;

  // Divider control: first pass on begin, second pass chained off the first
  always_comb begin
    div_start     = 1'b0;
    div_dividend  = in_random_value;
    div_divisor   = cells;
    div_phase_nxt = div_phase_r;
    start_rdy_nxt = start_rdy_r;
    start_col_nxt = start_col_r;
    start_row_nxt = start_row_r;
    if (in_acc && (in_operation == OP_BEGIN)) begin
      div_start     = 1'b1;
      div_phase_nxt = 1'b0;
      start_rdy_nxt = 1'b0;
    end else if (div_res.done && !div_phase_r) begin
      div_start     = 1'b1;
      div_dividend  = {{(RND_W-CNT_W){1'b0}}, div_res.rem};
      div_divisor   = {{(CNT_W-COORD_W){1'b0}}, rows};
      div_phase_nxt = 1'b1;
    end else if (div_res.done) begin
      start_col_nxt = div_res.quot[HALF_W-1:0];
      start_row_nxt = div_res.rem[HALF_W-1:0];
      start_rdy_nxt = 1'b1;
    end
  end

  // Main sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    begin_pend_nxt = begin_pend_r;
    walk_x_nxt     = walk_x_r;
    walk_y_nxt     = walk_y_r;
    total_nxt      = total_r;
    pick_nxt       = pick_r;
    wr_en          = 1'b0;
    wr_addr        = clr_cnt_r;
    wr_data        = 1'b0;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_wall_x_nxt = out_wall_x_r;
    out_wall_y_nxt = out_wall_y_r;
    out_carved_nxt = out_carved_r;
    out_cell_x_nxt = out_cell_x_r;
    out_cell_y_nxt = out_cell_y_r;
    out_fin_nxt    = out_fin_r;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == {IDX_W{1'b1}}) begin
          state_nxt = begin_pend_r ? ST_START : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_BEGIN) begin
            state_nxt      = ST_CLEAR;
            begin_pend_nxt = 1'b1;
          end else begin
            // map read of the chosen neighbour launched this edge
            state_nxt = ST_STEP;
            pick_nxt  = pick;
          end
        end
      end

      ST_STEP: begin
        if (out_free) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_carved_nxt = 1'b0;
          out_wall_x_nxt = '0;
          out_wall_y_nxt = '0;
          if (pick_r.valid) begin
            walk_x_nxt = pick_r.nx;
            walk_y_nxt = pick_r.ny;
            if (!rd_data_r) begin
              wr_en          = 1'b1;
              wr_addr        = pick_r.idx;
              wr_data        = 1'b1;
              total_nxt      = total_r + CNT_W'(1);
              out_carved_nxt = 1'b1;
              out_wall_x_nxt = pick_r.wx;
              out_wall_y_nxt = pick_r.wy;
            end
          end
          out_cell_x_nxt = walk_x_nxt;
          out_cell_y_nxt = walk_y_nxt;
          out_fin_nxt    = total_nxt >= cells;
        end
      end

      default: begin  // ST_START
        if (start_rdy_r && out_free) begin
          state_nxt      = ST_IDLE;
          begin_pend_nxt = 1'b0;
          walk_x_nxt     = {start_col_r, 1'b1};
          walk_y_nxt     = {start_row_r, 1'b1};
          // map is fresh, so the start cell is always new
          wr_en          = 1'b1;
          wr_addr        = {start_row_r, start_col_r};
          wr_data        = 1'b1;
          total_nxt      = CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_carved_nxt = 1'b0;
          out_wall_x_nxt = '0;
          out_wall_y_nxt = '0;
          out_cell_x_nxt = walk_x_nxt;
          out_cell_y_nxt = walk_y_nxt;
          out_fin_nxt    = total_nxt >= cells;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      begin_pend_r <= 1'b0;
      walk_x_r     <= COORD_W'(1);
      walk_y_r     <= COORD_W'(1);
      total_r      <= '0;
      div_phase_r  <= 1'b0;
      start_rdy_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      begin_pend_r <= begin_pend_nxt;
      walk_x_r     <= walk_x_nxt;
      walk_y_r     <= walk_y_nxt;
      total_r      <= total_nxt;
      div_phase_r  <= div_phase_nxt;
      start_rdy_r  <= start_rdy_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pick_r       <= pick_nxt;
    start_col_r  <= start_col_nxt;
    start_row_r  <= start_row_nxt;
    out_wall_x_r <= out_wall_x_nxt;
    out_wall_y_r <= out_wall_y_nxt;
    out_carved_r <= out_carved_nxt;
    out_cell_x_r <= out_cell_x_nxt;
    out_cell_y_r <= out_cell_y_nxt;
    out_fin_r    <= out_fin_nxt;
  end

  // While a step waits on the result slot, keep reading its own neighbour so
  // the visited bit survives a change on the request payload.
  assign rd_addr = (state_r == ST_STEP) ? pick_r.idx : pick.idx;

  // Visited map with a registered read port; the write-back comes from ST_STEP
  always_ff @(posedge clk) begin
    if (wr_en) vmap_mem[wr_addr] <= wr_data;
    rd_data_r <= vmap_mem[rd_addr];
  end

  assign out_valid    = out_valid_r;
  assign out_wall_x   = out_wall_x_r;
  assign out_wall_y   = out_wall_y_r;
  assign out_carved   = out_carved_r;
  assign out_cell_x   = out_cell_x_r;
  assign out_cell_y   = out_cell_y_r;
  assign out_finished = out_fin_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `RWMC_ASSERT_NEXT(a_step_to_resolve, in_acc && (in_operation == OP_STEP), state_r == ST_STEP)
  `RWMC_ASSERT_ALWAYS(a_total_bound, total_r <= CNT_W'(MAP_DEPTH))
  `RWMC_ASSERT_ALWAYS(a_wall_between,
                      !(out_valid_r && out_carved_r) || (out_wall_x_r[0] ^ out_wall_y_r[0]))
  `RWMC_ASSERT_ALWAYS(a_walk_on_cell, walk_x_r[0] && walk_y_r[0])

endmodule

// File: sv/rwmc_divider.sv
module rwmc_divider
  import rwmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output div_res_t         res
);

  localparam int STEP_W = $clog2(RND_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [RND_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, quo_r[RND_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(RND_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_nxt = {quo_r[RND_W-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

// File: sv/rwmc_pick.sv
module rwmc_pick
  import rwmc_pkg::*;
(
  input  logic [COORD_W-1:0] walk_x,
  input  logic [COORD_W-1:0] walk_y,
  input  logic [DIM_W-1:0]   dim_w,
  input  logic [DIM_W-1:0]   dim_h,
  input  logic [RND_W-1:0]   rnd,
  output pick_t              pick
);

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // 4 = 1 mod 3, so base-4 digit sums keep the residue
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    int         i;
    s = '0;
    for (i = 0; i < RND_W / 2; i++) begin
      s = s + {3'b0, v[2*i +: 2]};
    end
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b0, s[4]};
    u = {1'b0, t[1:0]} + {2'b0, t[2]};
    mod3 = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
  endfunction

  logic [3:0] ok;
  logic [2:0] n;
  logic [1:0] c;
  logic [2:0] cnt;
  logic [1:0] sel;
  int         d;

  assign ok[0] = ({1'b0, walk_x} + DIM_W'(2)) < dim_w;
  assign ok[1] = walk_x > COORD_W'(1);
  assign ok[2] = ({1'b0, walk_y} + DIM_W'(2)) < dim_h;
  assign ok[3] = walk_y > COORD_W'(1);
  assign n = {2'b0, ok[0]} + {2'b0, ok[1]} + {2'b0, ok[2]} + {2'b0, ok[3]};

  always_comb begin
    unique case (n)
      3'd2:    c = {1'b0, rnd[0]};
      3'd3:    c = mod3(rnd);
      3'd4:    c = rnd[1:0];
      default: c = 2'd0;
    endcase
  end

  // c-th neighbour in the order right, left, down, up
  always_comb begin
    cnt = '0;
    sel = DIR_RIGHT;
    for (d = 0; d < 4; d++) begin
      if (ok[d]) begin
        if (cnt == {1'b0, c}) sel = 2'(d);
        cnt = cnt + 3'd1;
      end
    end
  end

  always_comb begin
    pick.valid = n != 3'd0;
    pick.nx = walk_x;
    pick.ny = walk_y;
    pick.wx = walk_x;
    pick.wy = walk_y;
    unique case (sel)
      DIR_RIGHT: begin
        pick.nx = walk_x + COORD_W'(2);
        pick.wx = walk_x + COORD_W'(1);
      end
      DIR_LEFT: begin
        pick.nx = walk_x - COORD_W'(2);
        pick.wx = walk_x - COORD_W'(1);
      end
      DIR_DOWN: begin
        pick.ny = walk_y + COORD_W'(2);
        pick.wy = walk_y + COORD_W'(1);
      end
      default: begin
        pick.ny = walk_y - COORD_W'(2);
        pick.wy = walk_y - COORD_W'(1);
      end
    endcase
    pick.idx = {pick.ny[HALF_W:1], pick.nx[HALF_W:1]};
  end

endmodule
